// ===== design/pcfs_pkg.sv =====
`timescale 1ns / 1ps

package pcfs_pkg;

    // Input item codes
    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    // Configuration register indexes
    localparam int unsigned CFG_INDEX_W = 4;
    localparam int unsigned CFG_DATA_W  = 16;
    localparam logic [CFG_INDEX_W-1:0] CFG_CHARGE_COUNT   = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_STRENGTH_SCALE = 4'd1;
    localparam logic [15:0] SCALE_RESET = 16'd100;

    // Field accumulator format, Q19.28
    localparam int unsigned FIELD_W = 48;
    localparam logic signed [FIELD_W-1:0] FIELD_MAX = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [FIELD_W-1:0] FIELD_MIN = 48'sh8000_0000_0000;
    localparam logic signed [FIELD_W-1:0] COINC_TERM = 48'sd66;

    // Per charge divider: floor((n << 36) / m)
    localparam int unsigned DIV_NUM_W   = 32;
    localparam int unsigned DIV_SHIFT   = 36;
    localparam int unsigned DIV_Q_W     = DIV_NUM_W + DIV_SHIFT;
    localparam int unsigned DIV_DEN_W   = 58;
    localparam int unsigned TERM_MAG_W  = FIELD_W - 1;

    // Shared square root unit
    localparam int unsigned SQRT_W = 64;

    // Angle, units of 1/128 degree
    localparam logic signed [15:0] HALF_TURN = 16'sd23040;
    localparam int unsigned CORDIC_STEPS = 22;
    localparam logic [21:0] ATAN_TAB [CORDIC_STEPS] = '{
        22'd1474560, 22'd870484, 22'd459940, 22'd233473, 22'd117189, 22'd58652,
        22'd29333, 22'd14667, 22'd7334, 22'd3667, 22'd1833, 22'd917, 22'd458,
        22'd229, 22'd115, 22'd57, 22'd29, 22'd14, 22'd7, 22'd4, 22'd2, 22'd1
    };

    // One stored charge
    typedef struct packed {
        logic [15:0]        xpos;
        logic [15:0]        ypos;
        logic signed [15:0] value;
    } charge_entry_t;

endpackage

// ===== design/point_charge_field_sum.sv =====
`timescale 1ns / 1ps

// Field of a table of 2D point charges, summed at a queried location.
// Items enter on start when busy is low. func selects a load, which writes
// one charge into a table slot in the accept cycle and gives no result, or
// a query, which raises busy until its result leaves on done.
// The table is a ring of cells; a query rotates it one full turn, feeding
// the head cell into one interaction unit, so it returns to its load order.
// For each summed charge a query runs the 32-step square root, then two
// 68-step dividers side by side; a charge at the query point skips them.
// Then come strength (shared square root) and angle (22-step CORDIC, run
// in parallel). The ring keeps turning after the last summed charge, and
// a query ends only after the full turn. A load leaves busy low.
// Results show on field_x, field_y, strength and angle for the one cycle
// that done is high; the receiver cannot stall them.
// Configuration writes on cfg_valid are always taken (cfg_ready is high).
// Reset clears control and configuration (charge_count 0, strength_scale
// 100); table contents stay undefined until loaded.

module point_charge_field_sum #(
    parameter int MAX_CHARGES = 64
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic                                  func,
    input  logic [5:0]                            slot,
    input  logic [15:0]                           pos_x,
    input  logic [15:0]                           pos_y,
    input  logic signed [15:0]                    charge,
    output logic                                  done,
    output logic signed [pcfs_pkg::FIELD_W-1:0]   field_x,
    output logic signed [pcfs_pkg::FIELD_W-1:0]   field_y,
    output logic [pcfs_pkg::FIELD_W-1:0]          strength,
    output logic signed [15:0]                    angle,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [pcfs_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [pcfs_pkg::CFG_DATA_W-1:0]       cfg_data
);

    localparam int unsigned FW = pcfs_pkg::FIELD_W;
    localparam int unsigned KW = $clog2(MAX_CHARGES + 1);
    localparam int unsigned CW = (KW > 7) ? KW : 7;

    typedef enum logic [18:0] {
        S_IDLE       = 19'h00001,
        S_FETCH      = 19'h00002,
        S_MUL        = 19'h00004,
        S_SUM        = 19'h00008,
        S_ROOT_GO    = 19'h00010,
        S_ROOT_WAIT  = 19'h00020,
        S_MULM       = 19'h00040,
        S_DIV_GO     = 19'h00080,
        S_DIV_WAIT   = 19'h00100,
        S_TERM       = 19'h00200,
        S_ACC        = 19'h00400,
        S_POST_GO    = 19'h00800,
        S_NORM       = 19'h01000,
        S_SQ         = 19'h02000,
        S_SQSUM      = 19'h04000,
        S_SROOT_GO   = 19'h08000,
        S_SROOT_WAIT = 19'h10000,
        S_SCALE      = 19'h20000,
        S_FIN_WAIT   = 19'h40000
    } state_t;

    state_t state_reg, state_next;

    // Configuration
    logic [6:0]  count_reg;
    logic [15:0] scale_reg;

    // Query control
    logic [KW-1:0] k_reg, k_next;
    logic [KW-1:0] n_reg;
    logic [15:0]   px_reg;
    logic [15:0]   py_reg;
    logic          cord_flag_reg;

    // Interaction datapath
    logic signed [16:0]    dx_reg, dy_reg;
    logic signed [15:0]    q_reg;
    logic [31:0]           dxsq_reg, dysq_reg;
    logic [31:0]           nx_reg, ny_reg;
    logic                  negx_reg, negy_reg;
    logic [32:0]           s2_reg;
    logic [57:0]           m_reg;
    logic signed [FW-1:0]  term_x_reg, term_y_reg;
    logic signed [FW-1:0]  acc_x_reg, acc_y_reg;

    // Strength datapath
    logic [FW-1:0]  sax_reg, say_reg;
    logic [4:0]     shift_reg;
    logic [61:0]    sqx_reg, sqy_reg;
    logic [62:0]    ss_reg;

    // Result registers
    logic                  done_reg;
    logic signed [FW-1:0]  fx_out_reg, fy_out_reg;
    logic [FW-1:0]         str_reg, str_out_reg;
    logic signed [15:0]    ang_out_reg;

    // Ring of cells
    pcfs_pkg::charge_entry_t ring [MAX_CHARGES];
    pcfs_pkg::charge_entry_t load_entry;
    pcfs_pkg::charge_entry_t head;
    logic ring_shift;
    logic load_go;
    logic query_go;
    logic post_phase;

    // Shared units
    logic                         sqrt_start, sqrt_done;
    logic [pcfs_pkg::SQRT_W-1:0]  sqrt_in;
    logic [pcfs_pkg::SQRT_W/2-1:0] sqrt_root;
    logic                         div_start, divx_done, divy_done;
    logic [pcfs_pkg::TERM_MAG_W-1:0] tx, ty;
    logic                         cord_start, cord_done;
    logic signed [15:0]           cord_angle;

    logic signed [16:0] dx_now, dy_now;
    logic [15:0]        adx, ady, aq;
    logic [57:0]        m_prod;
    logic [48:0]        mag;
    logic [64:0]        str_prod;
    logic [FW-1:0]      sor;
    logic [CW-1:0]      cnt_ext;

    function automatic logic signed [FW-1:0] sat_add(
        input logic signed [FW-1:0] a,
        input logic signed [FW-1:0] b
    );
        logic [FW:0] s;
        s = {a[FW-1], a} + {b[FW-1], b};
        if (s[FW] != s[FW-1])
        begin
            sat_add = s[FW] ? pcfs_pkg::FIELD_MIN : pcfs_pkg::FIELD_MAX;
        end
        else
        begin
            sat_add = s[FW-1:0];
        end
    endfunction

    assign busy      = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;
    assign load_go   = start && !busy && (func == pcfs_pkg::FUNC_LOAD);
    assign query_go  = start && !busy && (func == pcfs_pkg::FUNC_QUERY);

    assign load_entry.xpos  = pos_x;
    assign load_entry.ypos  = pos_y;
    assign load_entry.value = charge;

    // Build the ring: each cell takes its successor's entry on a shift
    for (genvar i = 0; i < MAX_CHARGES; i++)
    begin : g_cell
        pcfs_cell u_cell (
            .clk        (clk),
            .load_en    (load_go && (32'(slot) == i)),
            .load_data  (load_entry),
            .shift_en   (ring_shift),
            .shift_data (ring[(i + 1) % MAX_CHARGES]),
            .entry      (ring[i])
        );
    end

    assign head = ring[0];

    // Difference to the head charge and magnitudes for the multipliers
    assign dx_now = $signed({1'b0, px_reg}) - $signed({1'b0, head.xpos});
    assign dy_now = $signed({1'b0, py_reg}) - $signed({1'b0, head.ypos});
    assign adx    = dx_reg[16] ? 16'(-dx_reg) : dx_reg[15:0];
    assign ady    = dy_reg[16] ? 16'(-dy_reg) : dy_reg[15:0];
    assign aq     = q_reg[15] ? 16'(-q_reg) : q_reg;
    assign m_prod = s2_reg * sqrt_root[24:0];

    assign sor      = sax_reg | say_reg;
    assign mag      = 49'(sqrt_root) << shift_reg;
    assign str_prod = mag * scale_reg;
    assign cnt_ext  = CW'(count_reg);

    assign post_phase = state_reg inside {S_POST_GO, S_NORM, S_SQ, S_SQSUM, S_SROOT_GO,
                                          S_SROOT_WAIT, S_SCALE, S_FIN_WAIT};
    assign ring_shift = (state_reg == S_ACC) ||
                        (post_phase && (k_reg != KW'(MAX_CHARGES)));

    assign sqrt_start = (state_reg == S_ROOT_GO) || (state_reg == S_SROOT_GO);
    assign sqrt_in    = (state_reg == S_SROOT_GO) ? {1'b0, ss_reg}
                                                  : {15'd0, s2_reg, 16'd0};
    assign div_start  = (state_reg == S_DIV_GO);
    assign cord_start = (state_reg == S_POST_GO);

    pcfs_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start),
        .radicand (sqrt_in),
        .done     (sqrt_done),
        .root     (sqrt_root)
    );

    pcfs_div u_div_x (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .numer    (nx_reg),
        .denom    (m_reg),
        .done     (divx_done),
        .quot_sat (tx)
    );

    pcfs_div u_div_y (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .numer    (ny_reg),
        .denom    (m_reg),
        .done     (divy_done),
        .quot_sat (ty)
    );

    pcfs_cordic u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cord_start),
        .fx    (acc_x_reg),
        .fy    (acc_y_reg),
        .done  (cord_done),
        .angle (cord_angle)
    );

    // Sequence one query
    always_comb
    begin
        state_next = state_reg;
        k_next     = k_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (query_go)
                begin
                    k_next = '0;
                    if (cnt_ext == '0)
                    begin
                        state_next = S_POST_GO;
                    end
                    else
                    begin
                        state_next = S_FETCH;
                    end
                end
            end
            S_FETCH:
            begin
                if (dx_now == '0 && dy_now == '0)
                begin
                    state_next = S_ACC;
                end
                else
                begin
                    state_next = S_MUL;
                end
            end
            S_MUL:       state_next = S_SUM;
            S_SUM:       state_next = S_ROOT_GO;
            S_ROOT_GO:   state_next = S_ROOT_WAIT;
            S_ROOT_WAIT:
            begin
                if (sqrt_done)
                begin
                    state_next = S_MULM;
                end
            end
            S_MULM:      state_next = S_DIV_GO;
            S_DIV_GO:    state_next = S_DIV_WAIT;
            S_DIV_WAIT:
            begin
                if (divx_done && divy_done)
                begin
                    state_next = S_TERM;
                end
            end
            S_TERM:      state_next = S_ACC;
            S_ACC:
            begin
                k_next = k_reg + KW'(1);
                if (k_reg + KW'(1) == n_reg)
                begin
                    state_next = S_POST_GO;
                end
                else
                begin
                    state_next = S_FETCH;
                end
            end
            S_POST_GO:   state_next = S_NORM;
            S_NORM:
            begin
                if (!(|sor[FW-1:31]))
                begin
                    state_next = S_SQ;
                end
            end
            S_SQ:        state_next = S_SQSUM;
            S_SQSUM:     state_next = S_SROOT_GO;
            S_SROOT_GO:  state_next = S_SROOT_WAIT;
            S_SROOT_WAIT:
            begin
                if (sqrt_done)
                begin
                    state_next = S_SCALE;
                end
            end
            S_SCALE:     state_next = S_FIN_WAIT;
            S_FIN_WAIT:
            begin
                if ((cord_flag_reg || cord_done) && k_reg == KW'(MAX_CHARGES))
                begin
                    state_next = S_IDLE;
                end
            end
            default:     state_next = S_IDLE;
        endcase
        // Finish the ring's turn after the last summed charge
        if (post_phase && k_reg != KW'(MAX_CHARGES))
        begin
            k_next = k_reg + KW'(1);
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            k_reg         <= '0;
            count_reg     <= 7'd0;
            scale_reg     <= pcfs_pkg::SCALE_RESET;
            cord_flag_reg <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
            done_reg  <= (state_reg == S_FIN_WAIT) && (state_next == S_IDLE);
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == pcfs_pkg::CFG_CHARGE_COUNT)
                begin
                    count_reg <= cfg_data[6:0];
                end
                else if (cfg_index == pcfs_pkg::CFG_STRENGTH_SCALE)
                begin
                    scale_reg <= cfg_data;
                end
            end
            if (state_reg == S_POST_GO)
            begin
                cord_flag_reg <= 1'b0;
            end
            else if (cord_done)
            begin
                cord_flag_reg <= 1'b1;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (query_go)
                begin
                    px_reg    <= pos_x;
                    py_reg    <= pos_y;
                    n_reg     <= (cnt_ext > CW'(MAX_CHARGES)) ? KW'(MAX_CHARGES)
                                                              : KW'(cnt_ext);
                    acc_x_reg <= '0;
                    acc_y_reg <= '0;
                end
            end
            S_FETCH:
            begin
                dx_reg     <= dx_now;
                dy_reg     <= dy_now;
                q_reg      <= head.value;
                term_x_reg <= pcfs_pkg::COINC_TERM;
                term_y_reg <= pcfs_pkg::COINC_TERM;
            end
            S_MUL:
            begin
                dxsq_reg <= adx * adx;
                dysq_reg <= ady * ady;
                nx_reg   <= aq * adx;
                ny_reg   <= aq * ady;
                negx_reg <= q_reg[15] ^ dx_reg[16];
                negy_reg <= q_reg[15] ^ dy_reg[16];
            end
            S_SUM:
            begin
                s2_reg <= 33'(dxsq_reg) + 33'(dysq_reg);
            end
            S_MULM:
            begin
                m_reg <= m_prod;
            end
            S_TERM:
            begin
                term_x_reg <= negx_reg ? -$signed({1'b0, tx}) : $signed({1'b0, tx});
                term_y_reg <= negy_reg ? -$signed({1'b0, ty}) : $signed({1'b0, ty});
            end
            S_ACC:
            begin
                acc_x_reg <= sat_add(acc_x_reg, term_x_reg);
                acc_y_reg <= sat_add(acc_y_reg, term_y_reg);
            end
            S_POST_GO:
            begin
                sax_reg   <= acc_x_reg[FW-1] ? FW'(-acc_x_reg) : acc_x_reg;
                say_reg   <= acc_y_reg[FW-1] ? FW'(-acc_y_reg) : acc_y_reg;
                shift_reg <= 5'd0;
            end
            S_NORM:
            begin
                // Drop low bits until both magnitudes fit in 31 bits
                if (|sor[FW-1:31])
                begin
                    sax_reg   <= sax_reg >> 1;
                    say_reg   <= say_reg >> 1;
                    shift_reg <= shift_reg + 5'd1;
                end
            end
            S_SQ:
            begin
                sqx_reg <= sax_reg[30:0] * sax_reg[30:0];
                sqy_reg <= say_reg[30:0] * say_reg[30:0];
            end
            S_SQSUM:
            begin
                ss_reg <= 63'(sqx_reg) + 63'(sqy_reg);
            end
            S_SCALE:
            begin
                str_reg <= (|str_prod[64:FW]) ? {FW{1'b1}} : str_prod[FW-1:0];
            end
            S_FIN_WAIT:
            begin
                fx_out_reg  <= acc_x_reg;
                fy_out_reg  <= acc_y_reg;
                str_out_reg <= str_reg;
                ang_out_reg <= cord_angle;
            end
            default:
            begin
            end
        endcase
    end

    assign done     = done_reg;
    assign field_x  = fx_out_reg;
    assign field_y  = fy_out_reg;
    assign strength = str_out_reg;
    assign angle    = ang_out_reg;

    // A result follows a busy cycle
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result without a query in progress");

    // A query holds the block busy
    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && func == pcfs_pkg::FUNC_QUERY) |=> busy)
        else $error("query accepted but block not busy");

    // A load leaves the block free
    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && func == pcfs_pkg::FUNC_LOAD) |=> !busy)
        else $error("load made the block busy");

    // The ring has made a full turn when a query ends
    a_ring_restored: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> ($past(k_reg) == KW'(MAX_CHARGES)))
        else $error("query ended with the ring out of order");

endmodule

// ===== design/pcfs_cell.sv =====
`timescale 1ns / 1ps

module pcfs_cell (
    input  logic                   clk,
    input  logic                   load_en,
    input  pcfs_pkg::charge_entry_t load_data,
    input  logic                   shift_en,
    input  pcfs_pkg::charge_entry_t shift_data,
    output pcfs_pkg::charge_entry_t entry
);

    pcfs_pkg::charge_entry_t entry_reg;

    // Take a load, else take the neighbor's entry, else hold
    always_ff @(posedge clk)
    begin
        if (load_en)
        begin
            entry_reg <= load_data;
        end
        else if (shift_en)
        begin
            entry_reg <= shift_data;
        end
    end

    assign entry = entry_reg;

endmodule

// ===== design/pcfs_sqrt.sv =====
`timescale 1ns / 1ps

module pcfs_sqrt (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic [pcfs_pkg::SQRT_W-1:0]      radicand,
    output logic                             done,
    output logic [pcfs_pkg::SQRT_W/2-1:0]    root
);

    localparam int unsigned W  = pcfs_pkg::SQRT_W;
    localparam int unsigned H  = W / 2;
    localparam int unsigned CW = $clog2(H);

    logic [W-1:0]  rad_reg;
    logic [H:0]    rem_reg;
    logic [H-1:0]  root_reg;
    logic [CW-1:0] cnt_reg;
    logic          run_reg;
    logic          done_reg;

    logic [H+2:0]  rem_sh;
    logic [H+2:0]  trial;
    logic          fits;

    // One root bit per cycle, two radicand bits enter the remainder
    assign rem_sh = {rem_reg, rad_reg[W-1:W-2]};
    assign trial  = {1'b0, root_reg, 2'b01};
    assign fits   = rem_sh >= trial;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CW'(H - 1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (run_reg)
        begin
            rad_reg <= {rad_reg[W-3:0], 2'b00};
            if (fits)
            begin
                rem_reg  <= (H+1)'(rem_sh - trial);
                root_reg <= {root_reg[H-2:0], 1'b1};
            end
            else
            begin
                rem_reg  <= rem_sh[H:0];
                root_reg <= {root_reg[H-2:0], 1'b0};
            end
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

// ===== design/pcfs_div.sv =====
`timescale 1ns / 1ps

module pcfs_div (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic [pcfs_pkg::DIV_NUM_W-1:0]      numer,
    input  logic [pcfs_pkg::DIV_DEN_W-1:0]      denom,
    output logic                                done,
    output logic [pcfs_pkg::TERM_MAG_W-1:0]     quot_sat
);

    localparam int unsigned QW = pcfs_pkg::DIV_Q_W;
    localparam int unsigned DW = pcfs_pkg::DIV_DEN_W;
    localparam int unsigned TW = pcfs_pkg::TERM_MAG_W;
    localparam int unsigned CW = $clog2(QW);

    logic [QW-1:0] sr_reg;
    logic [DW-1:0] den_reg;
    logic [DW-1:0] rem_reg;
    logic [CW-1:0] cnt_reg;
    logic          run_reg;
    logic          done_reg;

    logic [DW:0]   rem_sh;
    logic          fits;

    // Restoring division: dividend bits leave the top, quotient bits enter below
    assign rem_sh = {rem_reg, sr_reg[QW-1]};
    assign fits   = rem_sh >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CW'(QW - 1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            sr_reg  <= {numer, {pcfs_pkg::DIV_SHIFT{1'b0}}};
            den_reg <= denom;
            rem_reg <= '0;
        end
        else if (run_reg)
        begin
            if (fits)
            begin
                rem_reg <= DW'(rem_sh - {1'b0, den_reg});
            end
            else
            begin
                rem_reg <= rem_sh[DW-1:0];
            end
            sr_reg <= {sr_reg[QW-2:0], fits};
        end
    end

    // Clamp the quotient to the largest field magnitude
    assign quot_sat = (|sr_reg[QW-1:TW]) ? {TW{1'b1}} : sr_reg[TW-1:0];
    assign done     = done_reg;

endmodule

// ===== design/pcfs_cordic.sv =====
`timescale 1ns / 1ps

module pcfs_cordic (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    input  logic signed [pcfs_pkg::FIELD_W-1:0]    fx,
    input  logic signed [pcfs_pkg::FIELD_W-1:0]    fy,
    output logic                                   done,
    output logic signed [15:0]                     angle
);

    localparam int unsigned FW = pcfs_pkg::FIELD_W;

    typedef enum logic [3:0] {
        C_IDLE = 4'b0001,
        C_NORM = 4'b0010,
        C_ROT  = 4'b0100,
        C_FIN  = 4'b1000
    } cordic_state_t;

    cordic_state_t      state_reg;
    logic [FW-1:0]      ax_reg;
    logic [FW-1:0]      ay_reg;
    logic               neg_reg;
    logic signed [15:0] base_reg;
    logic signed [33:0] cx_reg;
    logic signed [33:0] cy_reg;
    logic signed [23:0] z_reg;
    logic [4:0]         i_reg;
    logic signed [15:0] angle_reg;
    logic               done_reg;

    logic [FW-1:0]      mag_or;
    logic signed [33:0] sx;
    logic signed [33:0] sy;
    logic signed [33:0] cx0;
    logic signed [23:0] tab_step;
    logic signed [23:0] z_round;
    logic signed [16:0] ang_sum;

    assign mag_or   = ax_reg | ay_reg;
    assign sx       = cx_reg >>> i_reg;
    assign sy       = cy_reg >>> i_reg;
    assign cx0      = $signed({4'b0000, ax_reg[29:0]});
    assign tab_step = $signed({2'b00, pcfs_pkg::ATAN_TAB[i_reg]});
    assign z_round  = (z_reg + 24'sd128) >>> 8;
    assign ang_sum  = 17'(base_reg) + 17'(z_round);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= C_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                C_IDLE:
                begin
                    if (start)
                    begin
                        if (fx == '0 && fy == '0)
                        begin
                            done_reg <= 1'b1;
                        end
                        else
                        begin
                            state_reg <= C_NORM;
                        end
                    end
                end
                C_NORM:
                begin
                    if (!(|mag_or[FW-1:30]) && mag_or[29])
                    begin
                        state_reg <= C_ROT;
                    end
                end
                C_ROT:
                begin
                    if (i_reg == 5'(pcfs_pkg::CORDIC_STEPS - 1))
                    begin
                        state_reg <= C_FIN;
                    end
                end
                C_FIN:
                begin
                    done_reg  <= 1'b1;
                    state_reg <= C_IDLE;
                end
                default:
                begin
                    state_reg <= C_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            C_IDLE:
            begin
                if (start)
                begin
                    // Fold the left half plane onto the right one
                    ax_reg   <= fx[FW-1] ? FW'(-fx) : fx;
                    ay_reg   <= fy[FW-1] ? FW'(-fy) : fy;
                    neg_reg  <= fx[FW-1] ? (!fy[FW-1] && fy != '0) : fy[FW-1];
                    base_reg <= fx[FW-1] ? (fy[FW-1] ? -pcfs_pkg::HALF_TURN
                                                     : pcfs_pkg::HALF_TURN) : 16'sd0;
                    angle_reg <= 16'sd0;
                end
            end
            C_NORM:
            begin
                // Bring the larger magnitude into [2^29, 2^30)
                if (|mag_or[FW-1:30])
                begin
                    ax_reg <= ax_reg >> 1;
                    ay_reg <= ay_reg >> 1;
                end
                else if (!mag_or[29])
                begin
                    ax_reg <= ax_reg << 1;
                    ay_reg <= ay_reg << 1;
                end
                else
                begin
                    cx_reg <= cx0;
                    cy_reg <= neg_reg ? -$signed({4'b0000, ay_reg[29:0]})
                                      : $signed({4'b0000, ay_reg[29:0]});
                    z_reg  <= 24'sd0;
                    i_reg  <= 5'd0;
                end
            end
            C_ROT:
            begin
                // Rotate toward the x axis
                if (!cy_reg[33])
                begin
                    cx_reg <= cx_reg + sy;
                    cy_reg <= cy_reg - sx;
                    z_reg  <= z_reg + tab_step;
                end
                else
                begin
                    cx_reg <= cx_reg - sy;
                    cy_reg <= cy_reg + sx;
                    z_reg  <= z_reg - tab_step;
                end
                i_reg <= i_reg + 5'd1;
            end
            C_FIN:
            begin
                if (ang_sum > 17'(pcfs_pkg::HALF_TURN))
                begin
                    angle_reg <= pcfs_pkg::HALF_TURN;
                end
                else if (ang_sum < -17'(pcfs_pkg::HALF_TURN))
                begin
                    angle_reg <= -pcfs_pkg::HALF_TURN;
                end
                else
                begin
                    angle_reg <= ang_sum[15:0];
                end
            end
            default:
            begin
            end
        endcase
    end

    assign done  = done_reg;
    assign angle = angle_reg;

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps

module tb;

    typedef enum logic [1:0] {K_OP, K_CFG, K_DRAIN} stim_kind_t;

    typedef struct {
        stim_kind_t         kind;
        logic               f;
        logic [5:0]         slot;
        logic [15:0]        px;
        logic [15:0]        py;
        logic signed [15:0] q;
        logic [3:0]         idx;
        logic [15:0]        data;
    } stim_t;

    typedef struct {
        longint              fx;
        longint              fy;
        longint unsigned     st;
        logic signed [15:0]  ang;
    } field_result_t;

    localparam longint F_MAX = 64'sh7FFF_FFFF_FFFF;
    localparam longint F_MIN = -64'sh8000_0000_0000;
    localparam longint unsigned M48 = 64'hFFFF_FFFF_FFFF;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic func = pcfs_pkg::FUNC_LOAD;
    logic [5:0] slot = '0;
    logic [15:0] pos_x = '0;
    logic [15:0] pos_y = '0;
    logic signed [15:0] charge = '0;
    logic cfg_valid = 1'b0;
    logic [pcfs_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [pcfs_pkg::CFG_DATA_W-1:0] cfg_data = '0;
    logic busy, done, cfg_ready;
    logic signed [pcfs_pkg::FIELD_W-1:0] field_x, field_y;
    logic [pcfs_pkg::FIELD_W-1:0] strength;
    logic signed [15:0] angle;

    point_charge_field_sum uut (.*);

    always #2 clk = ~clk;

    // Stimulus store and predictor state
    stim_t pending_items[$];
    field_result_t expected_fields[$];
    logic [15:0] tab_x[64];
    logic [15:0] tab_y[64];
    logic signed [15:0] tab_q[64];
    logic [6:0] mdl_count = 7'd0;
    logic [15:0] mdl_scale = pcfs_pkg::SCALE_RESET;
    int errors = 0;
    int n_loads = 0;
    int n_queries = 0;
    int n_checked = 0;
    int n_cfg = 0;
    bit stim_done = 1'b0;

    // Generator's view of the charge positions
    logic [15:0] gen_x[64];
    logic [15:0] gen_y[64];

    function automatic longint unsigned isqrt64(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
            begin
                r = r >> 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic longint mag64(longint v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic longint sat48(longint a, longint b);
        longint s;
        s = a + b;
        if (s > F_MAX) s = F_MAX;
        if (s < F_MIN) s = F_MIN;
        return s;
    endfunction

    // One signed component of q*d/|d|^3
    function automatic longint charge_term(longint q, longint d, longint unsigned m);
        logic [127:0] num;
        logic [127:0] t;
        longint v;
        num = 128'(mag64(q) * mag64(d)) << 36;
        t = num / 128'(m);
        if (t > 128'(F_MAX)) t = 128'(F_MAX);
        v = longint'(t[63:0]);
        return ((q < 0) != (d < 0)) ? -v : v;
    endfunction

    function automatic logic signed [15:0] field_angle(longint fx, longint fy);
        longint x, y, base, cx, cy, z, sx, sy, tot, ang;
        longint unsigned ax, ay, m;
        bit neg;
        x = fx;
        y = fy;
        base = 0;
        z = 0;
        if (fx == 0 && fy == 0) return 16'sd0;
        if (x < 0)
        begin
            x = -x;
            y = -y;
            base = (fy >= 0) ? longint'(pcfs_pkg::HALF_TURN)
                             : -longint'(pcfs_pkg::HALF_TURN);
        end
        ax = x;
        neg = (y < 0);
        ay = mag64(y);
        m = (ax > ay) ? ax : ay;
        while (m >= (64'd1 << 30))
        begin
            ax >>= 1; ay >>= 1; m >>= 1;
        end
        while (m < (64'd1 << 29))
        begin
            ax <<= 1; ay <<= 1; m <<= 1;
        end
        cx = ax;
        cy = neg ? -longint'(ay) : longint'(ay);
        for (int i = 0; i < pcfs_pkg::CORDIC_STEPS; i++)
        begin
            sx = cx >>> i;
            sy = cy >>> i;
            if (cy >= 0)
            begin
                cx += sy; cy -= sx; z += longint'(pcfs_pkg::ATAN_TAB[i]);
            end
            else
            begin
                cx -= sy; cy += sx; z -= longint'(pcfs_pkg::ATAN_TAB[i]);
            end
        end
        tot = base * 256 + z + 128 + (64'sd1 << 30);
        ang = (tot >>> 8) - (64'sd1 << 22);
        if (ang > pcfs_pkg::HALF_TURN) ang = pcfs_pkg::HALF_TURN;
        if (ang < -pcfs_pkg::HALF_TURN) ang = -pcfs_pkg::HALF_TURN;
        return ang[15:0];
    endfunction

    function automatic longint unsigned field_strength(longint fx, longint fy);
        longint unsigned ax, ay, mag, sc;
        int s;
        ax = mag64(fx);
        ay = mag64(fy);
        s = 0;
        sc = mdl_scale;
        while (ax >= (64'd1 << 31) || ay >= (64'd1 << 31))
        begin
            ax >>= 1; ay >>= 1; s++;
        end
        mag = isqrt64(ax * ax + ay * ay) << s;
        if (sc != 0 && mag > M48 / sc) return M48;
        return mag * sc;
    endfunction

    function automatic field_result_t predict_field(logic [15:0] px, logic [15:0] py);
        field_result_t r;
        longint acc_x, acc_y, dx, dy;
        longint unsigned s2, rt, n;
        acc_x = 0;
        acc_y = 0;
        n = (mdl_count < 64) ? mdl_count : 64;
        for (int k = 0; k < n; k++)
        begin
            dx = longint'(px) - longint'(tab_x[k]);
            dy = longint'(py) - longint'(tab_y[k]);
            if (dx == 0 && dy == 0)
            begin
                acc_x = sat48(acc_x, pcfs_pkg::COINC_TERM);
                acc_y = sat48(acc_y, pcfs_pkg::COINC_TERM);
            end
            else
            begin
                s2 = dx * dx + dy * dy;
                rt = isqrt64(s2 << 16);
                acc_x = sat48(acc_x, charge_term(tab_q[k], dx, s2 * rt));
                acc_y = sat48(acc_y, charge_term(tab_q[k], dy, s2 * rt));
            end
        end
        r.fx = acc_x;
        r.fy = acc_y;
        r.st = field_strength(acc_x, acc_y) & M48;
        r.ang = field_angle(acc_x, acc_y);
        return r;
    endfunction

    function automatic int n_loads_planned();
        int c;
        c = 0;
        foreach (pending_items[i]) if (pending_items[i].kind == K_OP) c++;
        return c;
    endfunction

    // Driver: hold each item until taken, idle in bursts, wait for quiet before cfg
    int gap = 0;
    int quiet = 0;
    always @(posedge clk)
    begin
        stim_t it;
        bit taken, cfg_taken, holding;
        if (rst_n)
        begin
            taken = start && !busy;
            cfg_taken = cfg_valid && cfg_ready;
            holding = (start && !taken) || (cfg_valid && !cfg_taken);
            if (!holding)
            begin
                if ((taken || cfg_taken) && pending_items.size() > 150
                        && $urandom_range(0, 7) == 0)
                    gap = $urandom_range(1, 17);
                if (gap > 0)
                begin
                    gap--;
                    start <= 1'b0;
                    cfg_valid <= 1'b0;
                end
                else if (pending_items.size() == 0)
                begin
                    start <= 1'b0;
                    cfg_valid <= 1'b0;
                    stim_done = 1'b1;
                end
                else if (pending_items[0].kind == K_OP)
                begin
                    it = pending_items.pop_front();
                    start <= 1'b1;
                    cfg_valid <= 1'b0;
                    func <= it.f;
                    slot <= it.slot;
                    pos_x <= it.px;
                    pos_y <= it.py;
                    charge <= it.q;
                    quiet = 0;
                end
                else
                begin
                    start <= 1'b0;
                    cfg_valid <= 1'b0;
                    if (expected_fields.size() == 0 && !busy && !taken) quiet++;
                    else quiet = 0;
                    if (quiet >= 8)
                    begin
                        it = pending_items.pop_front();
                        quiet = 0;
                        if (it.kind == K_CFG)
                        begin
                            cfg_valid <= 1'b1;
                            cfg_index <= it.idx;
                            cfg_data <= it.data;
                        end
                    end
                end
            end
        end
    end

    // Monitor: track accepted items, predict, check results
    always @(posedge clk)
    begin
        field_result_t e;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                n_cfg++;
                if (cfg_index == pcfs_pkg::CFG_CHARGE_COUNT) mdl_count = cfg_data[6:0];
                else if (cfg_index == pcfs_pkg::CFG_STRENGTH_SCALE) mdl_scale = cfg_data;
            end
            if (done)
            begin
                if (expected_fields.size() == 0)
                begin
                    $error("result with no query pending");
                    errors++;
                end
                else
                begin
                    e = expected_fields.pop_front();
                    n_checked++;
                    if (field_x !== e.fx[47:0])
                    begin
                        $error("field_x expected %0d got %0d", e.fx, field_x);
                        errors++;
                    end
                    if (field_y !== e.fy[47:0])
                    begin
                        $error("field_y expected %0d got %0d", e.fy, field_y);
                        errors++;
                    end
                    if (strength !== e.st[47:0])
                    begin
                        $error("strength expected %0d got %0d", e.st, strength);
                        errors++;
                    end
                    if (angle !== e.ang)
                    begin
                        $error("angle expected %0d got %0d", e.ang, angle);
                        errors++;
                    end
                end
            end
            if (start && !busy)
            begin
                if (func == pcfs_pkg::FUNC_LOAD)
                begin
                    n_loads++;
                    tab_x[slot] = pos_x;
                    tab_y[slot] = pos_y;
                    tab_q[slot] = charge;
                end
                else
                begin
                    n_queries++;
                    expected_fields.push_back(predict_field(pos_x, pos_y));
                end
            end
        end
    end

    task automatic add_load(int s, logic [15:0] x, logic [15:0] y, logic signed [15:0] q);
        stim_t it;
        it = '{K_OP, pcfs_pkg::FUNC_LOAD, s[5:0], x, y, q, 4'd0, 16'd0};
        gen_x[s] = x;
        gen_y[s] = y;
        pending_items.push_back(it);
    endtask

    task automatic add_query(logic [15:0] x, logic [15:0] y);
        stim_t it;
        it = '{K_OP, pcfs_pkg::FUNC_QUERY, 6'($urandom), x, y, 16'($urandom), 4'd0, 16'd0};
        pending_items.push_back(it);
    endtask

    task automatic add_cfg(logic [3:0] idx, logic [15:0] data);
        stim_t it;
        it = '{K_CFG, pcfs_pkg::FUNC_LOAD, 6'd0, 16'd0, 16'd0, 16'sd0, idx, data};
        pending_items.push_back(it);
    endtask

    task automatic add_drain();
        stim_t it;
        it = '{K_DRAIN, pcfs_pkg::FUNC_LOAD, 6'd0, 16'd0, 16'd0, 16'sd0, 4'd0, 16'd0};
        pending_items.push_back(it);
    endtask

    // Limit on the whole run
    initial
    begin
        #200ms;
        $display("status: fail");
        $finish;
    end

    initial
    begin
        int s, r;
        logic [15:0] x, y;
        // Fill every slot so no query reads an unwritten one
        add_load(0, 16'h0000, 16'h0000, 16'sh8000);
        add_load(1, 16'hFFFF, 16'hFFFF, 16'sd32767);
        for (int k = 2; k < 64; k++)
            add_load(k, 16'($urandom), 16'($urandom), 16'($urandom));
        // Directed: empty sum, coincident charge, extremes, clamp beyond table
        add_cfg(pcfs_pkg::CFG_CHARGE_COUNT, 16'd0);
        add_query(16'h1234, 16'h4321);
        add_drain();
        add_cfg(pcfs_pkg::CFG_CHARGE_COUNT, 16'd2);
        add_query(16'h0000, 16'h0000);
        add_query(16'hFFFF, 16'hFFFF);
        add_query(16'h0001, 16'h0000);
        add_query(16'h8000, 16'h8000);
        add_drain();
        add_cfg(pcfs_pkg::CFG_STRENGTH_SCALE, 16'd0);
        add_query(16'h0040, 16'h0000);
        add_drain();
        add_cfg(pcfs_pkg::CFG_STRENGTH_SCALE, 16'hFFFF);
        add_query(16'h0040, 16'h0000);
        add_drain();
        add_cfg(pcfs_pkg::CFG_CHARGE_COUNT, 16'd127);
        add_query(16'h7000, 16'h2000);
        // Saturation: a cluster of strong charges one step from the query point
        for (int k = 2; k < 22; k++) add_load(k, 16'h4000, 16'h4000, 16'sd32767);
        add_drain();
        add_cfg(pcfs_pkg::CFG_CHARGE_COUNT, 16'd22);
        add_cfg(pcfs_pkg::CFG_STRENGTH_SCALE, pcfs_pkg::SCALE_RESET);
        add_query(16'h4001, 16'h4001);
        add_query(16'h3FFF, 16'h4000);
        // Random phases with new settings between them
        while (n_loads_planned() < 1550)
        begin
            add_drain();
            r = $urandom_range(0, 19);
            add_cfg(pcfs_pkg::CFG_CHARGE_COUNT, (r == 0) ? 16'd64 : (r == 1) ? 16'd127
                    : 16'($urandom_range(0, 6)));
            r = $urandom_range(0, 9);
            add_cfg(pcfs_pkg::CFG_STRENGTH_SCALE, (r == 0) ? 16'd0 : (r == 1) ? 16'hFFFF
                    : 16'($urandom));
            for (int k = 0; k < 40; k++)
            begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3: add_load($urandom_range(0, 7), 16'($urandom),
                                         16'($urandom), 16'($urandom));
                    4:
                    begin
                        s = $urandom_range(0, 7);
                        add_query(gen_x[s], gen_y[s]);
                    end
                    5: add_query(16'($urandom), 16'($urandom));
                    default:
                    begin
                        s = $urandom_range(0, 7);
                        x = gen_x[s] + 16'($signed($urandom_range(0, 64)) - 32);
                        y = gen_y[s] + 16'($signed($urandom_range(0, 64)) - 32);
                        add_query(x, y);
                    end
                endcase
            end
        end
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        wait (stim_done);
        // Let the monitor record the last accepted item
        repeat (2) @(posedge clk);
        while (expected_fields.size() != 0) @(posedge clk);
        repeat (200) @(posedge clk);
        $display("loads %0d, queries %0d, results checked %0d, register writes %0d",
                 n_loads, n_queries, n_checked, n_cfg);
        if (errors == 0 && expected_fields.size() == 0) $display("status: pass");
        else $display("status: fail");
        $finish;
    end

endmodule
